// ===== hw/rtl/wph_pkg.sv =====
// Shared types and constants for the WAV PCM header parser.
`default_nettype none
package wph_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StBadTag      = 3'd1;
  localparam logic [2:0] StBadFmtSize  = 3'd2;
  localparam logic [2:0] StNotPcm      = 3'd3;
  localparam logic [2:0] StTruncated   = 3'd4;
  localparam logic [2:0] StBadChannels = 3'd5;
  localparam logic [2:0] StBadBits     = 3'd6;

  localparam logic [1:0] FmtMono8    = 2'd0;
  localparam logic [1:0] FmtMono16   = 2'd1;
  localparam logic [1:0] FmtStereo8  = 2'd2;
  localparam logic [1:0] FmtStereo16 = 2'd3;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status_code;
    logic [1:0]  sample_format;
    logic [31:0] sample_rate_out;
    logic [31:0] data_length_out;
    logic        last_in_run;
  } out_t;

  typedef struct packed {
    logic        has_payload;
    logic        has_status;
    logic [7:0]  payload_byte;
    logic [2:0]  status_code;
    logic [1:0]  sample_format;
    logic [31:0] rate;
    logic [31:0] length;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wph_front.sv =====
// Front end: header parsing and classification of each input byte into a command.
`default_nettype none
module wph_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  wire wph_pkg::in_t  in_data_i,
  output logic               push_o,
  output wph_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhDone    = 2'd2
  } phase_e;

  localparam logic [5:0] PosRiff  = 6'd3;
  localparam logic [5:0] PosWave  = 6'd11;
  localparam logic [5:0] PosFmt   = 6'd15;
  localparam logic [5:0] PosFmtSz = 6'd19;
  localparam logic [5:0] PosAudio = 6'd21;
  localparam logic [5:0] PosChan  = 6'd23;
  localparam logic [5:0] PosRate  = 6'd27;
  localparam logic [5:0] PosBits  = 6'd35;
  localparam logic [5:0] PosData  = 6'd39;
  localparam logic [5:0] PosLen   = 6'd43;

  localparam logic [31:0] TagRiff     = 32'h4646_4952;
  localparam logic [31:0] TagWave     = 32'h4556_4157;
  localparam logic [31:0] TagFmt      = 32'h2074_6D66;
  localparam logic [31:0] TagData     = 32'h6174_6164;
  localparam logic [31:0] FmtChunkLen = 32'd16;

  phase_e      phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] len_q, len_d;
  logic [31:0] seen_q, seen_d;

  logic [31:0] shift_nx;
  logic [15:0] half;
  logic [2:0]  bad;
  logic [2:0]  fc_code;
  logic [1:0]  fc_fmt;
  logic        in_acc;
  wph_pkg::cmd_t cmd;

  assign in_acc   = in_valid_i && !in_stall_i;
  assign shift_nx = {in_data_i.in_byte, shift_q[31:8]};
  assign half     = shift_nx[31:16];

  always_comb begin
    fc_fmt = {(chan_q == 16'd2), (bits_q == 16'd16)};
    if (chan_q != 16'd1 && chan_q != 16'd2) begin
      fc_code = wph_pkg::StBadChannels;
      fc_fmt  = wph_pkg::FmtMono8;
    end else if (bits_q != 16'd8 && bits_q != 16'd16) begin
      fc_code = wph_pkg::StBadBits;
      fc_fmt  = wph_pkg::FmtMono8;
    end else begin
      fc_code = wph_pkg::StOk;
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    shift_d = shift_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    len_d   = len_q;
    seen_d  = seen_q;
    bad     = wph_pkg::StOk;
    cmd     = '0;
    if (in_acc) begin
      case (phase_q)
        PhHeader: begin
          shift_d = shift_nx;
          case (pos_q)
            PosRiff:  if (shift_nx != TagRiff) bad = wph_pkg::StBadTag;
            PosWave:  if (shift_nx != TagWave) bad = wph_pkg::StBadTag;
            PosFmt:   if (shift_nx != TagFmt) bad = wph_pkg::StBadTag;
            PosFmtSz: if (shift_nx != FmtChunkLen) bad = wph_pkg::StBadFmtSize;
            PosAudio: if (half != 16'd1) bad = wph_pkg::StNotPcm;
            PosChan:  chan_d = half;
            PosRate:  rate_d = shift_nx;
            PosBits:  bits_d = half;
            PosData:  if (shift_nx != TagData) bad = wph_pkg::StBadTag;
            PosLen:   len_d = shift_nx;
            default: ;
          endcase
          if (bad != wph_pkg::StOk) begin
            cmd.has_status  = 1'b1;
            cmd.status_code = bad;
            phase_d         = PhDone;
          end else if (pos_q >= PosLen) begin
            phase_d = PhPayload;
            seen_d  = '0;
            if (len_d == 32'd0) begin
              cmd.has_status    = 1'b1;
              cmd.status_code   = fc_code;
              cmd.sample_format = fc_fmt;
              phase_d           = PhDone;
            end else if (in_data_i.end_of_file) begin
              cmd.has_status  = 1'b1;
              cmd.status_code = wph_pkg::StTruncated;
              phase_d         = PhDone;
            end
          end else begin
            pos_d = pos_q + 6'd1;
            if (in_data_i.end_of_file) begin
              cmd.has_status  = 1'b1;
              cmd.status_code = wph_pkg::StTruncated;
              phase_d         = PhDone;
            end
          end
        end
        PhPayload: begin
          cmd.has_payload  = 1'b1;
          cmd.payload_byte = in_data_i.in_byte;
          seen_d           = seen_q + 32'd1;
          if (seen_d == len_q) begin
            cmd.has_status    = 1'b1;
            cmd.status_code   = fc_code;
            cmd.sample_format = fc_fmt;
            phase_d           = PhDone;
          end else if (in_data_i.end_of_file) begin
            cmd.has_status  = 1'b1;
            cmd.status_code = wph_pkg::StTruncated;
            phase_d         = PhDone;
          end
        end
        default: ;
      endcase
      if (cmd.has_status) begin
        cmd.rate   = rate_d;
        cmd.length = len_d;
      end
      if (in_data_i.end_of_file) begin
        phase_d = PhHeader;
        pos_d   = '0;
        shift_d = '0;
        chan_d  = '0;
        rate_d  = '0;
        bits_d  = '0;
        len_d   = '0;
        seen_d  = '0;
      end
    end
  end

  assign push_o = cmd.has_payload || cmd.has_status;
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= '0;
      shift_q <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      len_q   <= '0;
      seen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wph_queue.sv =====
// Command queue between the front end and the back end.
`default_nettype none
module wph_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wph_pkg::cmd_t push_data_i,
  input  wire logic          pop_i,
  output wph_pkg::cmd_t      head_o,
  output logic               empty_o,
  output logic               full_o
);

  localparam logic [wph_pkg::QueuePtrW-1:0] PtrOne   = 1;
  localparam logic [wph_pkg::QueuePtrW:0]   CountOne = 1;

  wph_pkg::cmd_t entries_q [wph_pkg::QueueDepth];
  logic [wph_pkg::QueuePtrW-1:0] wptr_q, rptr_q;
  logic [wph_pkg::QueuePtrW:0]   count_q;
  logic do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (wph_pkg::QueuePtrW+1)'(wph_pkg::QueueDepth));
  assign head_o  = entries_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PtrOne;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PtrOne;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountOne;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountOne;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wph_back.sv =====
// Back end: expands queued commands into result transactions on the output register.
`default_nettype none
module wph_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wph_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output wph_pkg::out_t      out_data_o
);

  wph_pkg::out_t out_q, out_d;
  logic          valid_q, valid_d;
  logic          sub_q, sub_d;
  logic          load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    out_d   = out_q;
    valid_d = valid_q && out_stall_i;
    sub_d   = sub_q;
    pop_o   = 1'b0;
    if (load && !empty_i) begin
      valid_d = 1'b1;
      out_d   = '0;
      if (head_i.has_payload && !sub_q) begin
        out_d.item_kind    = wph_pkg::KindPayload;
        out_d.payload_byte = head_i.payload_byte;
        out_d.last_in_run  = !head_i.has_status;
        if (head_i.has_status) begin
          sub_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        out_d.item_kind       = wph_pkg::KindStatus;
        out_d.status_code     = head_i.status_code;
        out_d.sample_format   = head_i.sample_format;
        out_d.sample_rate_out = head_i.rate;
        out_d.data_length_out = head_i.length;
        out_d.last_in_run     = 1'b1;
        sub_d                 = 1'b0;
        pop_o                 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sub_q   <= sub_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/wav_pcm_header_parser_core.sv =====
// Top level of the WAV PCM header parser: front end, command queue, back end.
// Results pass through the command queue and the output register.
// Throughput: one byte per cycle while the queue is not full; a byte ending the payload
// gives two results. The four-entry command queue absorbs these and output stalls.
// Reset clears the parser state, empties the queue and drops the output valid;
// end of file rearms the parser.
`default_nettype none
module wav_pcm_header_parser_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire wph_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output wph_pkg::out_t      out_data_o
);

  wph_pkg::cmd_t push_cmd, head;
  logic          push, pop, empty, full;

  assign in_stall_o = full;

  wph_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (full),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  wph_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  wph_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_kind == wph_pkg::KindStatus |-> out_data_o.last_in_run)
    else $error("status transaction without last_in_run");

  a_payload_then_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.item_kind == wph_pkg::KindPayload &&
    !out_data_o.last_in_run
    |=> out_valid_o && out_data_o.item_kind == wph_pkg::KindStatus)
    else $error("payload transaction not followed by its status");

  a_format_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status_code != wph_pkg::StOk
    |-> out_data_o.sample_format == wph_pkg::FmtMono8)
    else $error("format code given with failing status");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the WAV PCM header parser: directed header rows, then random files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wph_pkg::*;

  localparam logic [31:0] TagRiff     = 32'h4646_4952;
  localparam logic [31:0] TagWave     = 32'h4556_4157;
  localparam logic [31:0] TagFmt      = 32'h2074_6D66;
  localparam logic [31:0] TagData     = 32'h6174_6164;
  localparam logic [31:0] FmtChunkLen = 32'd16;
  localparam logic [15:0] AudioPcm    = 16'd1;
  localparam logic [5:0]  LastHdrPos  = 6'd43;
  localparam int unsigned NumItems    = 1400;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned MaxReported = 10;

  typedef enum logic [1:0] {PhHeader, PhPayload, PhDone} phase_e;

  typedef struct packed {
    logic [7:0] by;
    logic       eof;
    logic       typed;
    logic       has_status;
    logic [2:0] code;
  } row_t;

  typedef logic [$bits(out_t)-1:0] flat_t;

  localparam int NumRows = 25;
  localparam row_t DirectedRows [NumRows] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, StTruncated},
    '{8'hFF, 1'b1, 1'b1, 1'b1, StTruncated},
    '{"R",   1'b0, 1'b1, 1'b0, StOk},
    '{"I",   1'b0, 1'b1, 1'b0, StOk},
    '{"F",   1'b0, 1'b1, 1'b0, StOk},
    '{"X",   1'b0, 1'b1, 1'b1, StBadTag},
    '{8'hFF, 1'b1, 1'b1, 1'b0, StOk},
    '{"R",   1'b0, 1'b0, 1'b0, StOk},
    '{"I",   1'b0, 1'b0, 1'b0, StOk},
    '{"F",   1'b0, 1'b0, 1'b0, StOk},
    '{"F",   1'b0, 1'b0, 1'b0, StOk},
    '{"W",   1'b1, 1'b1, 1'b1, StTruncated},
    '{"R",   1'b0, 1'b0, 1'b0, StOk},
    '{"I",   1'b0, 1'b0, 1'b0, StOk},
    '{"F",   1'b0, 1'b0, 1'b0, StOk},
    '{"F",   1'b0, 1'b0, 1'b0, StOk},
    '{8'h00, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h80, 1'b0, 1'b0, 1'b0, StOk},
    '{"W",   1'b0, 1'b0, 1'b0, StOk},
    '{"A",   1'b0, 1'b0, 1'b0, StOk},
    '{"V",   1'b0, 1'b0, 1'b0, StOk},
    '{"E",   1'b0, 1'b0, 1'b0, StOk},
    '{"f",   1'b1, 1'b1, 1'b1, StTruncated}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  out_t        pending_results [$];
  logic [7:0]  file_bytes [$];
  int unsigned bytes_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  logic        steady;

  phase_e      phase;
  logic [5:0]  hdr_pos;
  logic [31:0] shift_reg;
  logic [15:0] chan_cnt;
  logic [31:0] rate_reg;
  logic [15:0] depth_reg;
  logic [31:0] len_reg;
  logic [31:0] payload_cnt;

  assign steady = (bytes_sent >= 500) && (bytes_sent < 800);

  wav_pcm_header_parser_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_parser();
    phase       = PhHeader;
    hdr_pos     = '0;
    shift_reg   = '0;
    chan_cnt    = '0;
    rate_reg    = '0;
    depth_reg   = '0;
    len_reg     = '0;
    payload_cnt = '0;
  endfunction

  function automatic out_t status_item(input logic [2:0] code, input logic [1:0] fmt);
    out_t r;
    r                 = '0;
    r.item_kind       = KindStatus;
    r.status_code     = code;
    r.sample_format   = fmt;
    r.sample_rate_out = rate_reg;
    r.data_length_out = len_reg;
    phase             = PhDone;
    return r;
  endfunction

  function automatic out_t closing_status();
    logic [1:0] fmt;
    if (chan_cnt != 16'd1 && chan_cnt != 16'd2) return status_item(StBadChannels, FmtMono8);
    if (depth_reg != 16'd8 && depth_reg != 16'd16) return status_item(StBadBits, FmtMono8);
    if (chan_cnt == 16'd1) fmt = (depth_reg == 16'd8) ? FmtMono8 : FmtMono16;
    else fmt = (depth_reg == 16'd8) ? FmtStereo8 : FmtStereo16;
    return status_item(StOk, fmt);
  endfunction

  function automatic void predict_results(input in_t b, input bit keep);
    out_t       res [2];
    int         n;
    logic [2:0] bad;
    logic [5:0] pos;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    case (phase)
      PhHeader: begin
        pos       = hdr_pos;
        bad       = StOk;
        shift_reg = {b.in_byte, shift_reg[31:8]};
        case (pos)
          6'd3:  if (shift_reg != TagRiff) bad = StBadTag;
          6'd11: if (shift_reg != TagWave) bad = StBadTag;
          6'd15: if (shift_reg != TagFmt) bad = StBadTag;
          6'd19: if (shift_reg != FmtChunkLen) bad = StBadFmtSize;
          6'd21: if (shift_reg[31:16] != AudioPcm) bad = StNotPcm;
          6'd23: chan_cnt = shift_reg[31:16];
          6'd27: rate_reg = shift_reg;
          6'd35: depth_reg = shift_reg[31:16];
          6'd39: if (shift_reg != TagData) bad = StBadTag;
          6'd43: len_reg = shift_reg;
          default: ;
        endcase
        if (bad != StOk) begin
          res[n] = status_item(bad, FmtMono8);
          n++;
        end else if (pos >= LastHdrPos) begin
          phase       = PhPayload;
          payload_cnt = '0;
          if (len_reg == '0) begin
            res[n] = closing_status();
            n++;
          end else if (b.end_of_file) begin
            res[n] = status_item(StTruncated, FmtMono8);
            n++;
          end
        end else begin
          hdr_pos = pos + 6'd1;
          if (b.end_of_file) begin
            res[n] = status_item(StTruncated, FmtMono8);
            n++;
          end
        end
      end
      PhPayload: begin
        res[n].item_kind    = KindPayload;
        res[n].payload_byte = b.in_byte;
        n++;
        payload_cnt++;
        if (payload_cnt == len_reg) begin
          res[n] = closing_status();
          n++;
        end else if (b.end_of_file) begin
          res[n] = status_item(StTruncated, FmtMono8);
          n++;
        end
      end
      default: ;
    endcase
    if (n > 0) res[n-1].last_in_run = 1'b1;
    if (b.end_of_file) clear_parser();
    if (keep) for (int k = 0; k < n; k++) pending_results.push_back(res[k]);
  endfunction

  function automatic void push_le(input logic [31:0] value, input int nbytes);
    for (int k = 0; k < nbytes; k++) file_bytes.push_back(value[8*k +: 8]);
  endfunction

  task automatic feed_byte(input in_t b, input bit keep);
    while (!steady && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    predict_results(b, keep);
  endtask

  task automatic note_mismatch(input string what, input flat_t want, input flat_t got);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 10);

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected transaction", '0, out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.item_kind !== want.item_kind)
          note_mismatch("item_kind", flat_t'(want.item_kind),
                        flat_t'(out_data_o.item_kind));
        if (out_data_o.payload_byte !== want.payload_byte)
          note_mismatch("payload_byte", flat_t'(want.payload_byte),
                        flat_t'(out_data_o.payload_byte));
        if (out_data_o.status_code !== want.status_code)
          note_mismatch("status_code", flat_t'(want.status_code),
                        flat_t'(out_data_o.status_code));
        if (out_data_o.sample_format !== want.sample_format)
          note_mismatch("sample_format", flat_t'(want.sample_format),
                        flat_t'(out_data_o.sample_format));
        if (out_data_o.sample_rate_out !== want.sample_rate_out)
          note_mismatch("sample_rate_out", flat_t'(want.sample_rate_out),
                        flat_t'(out_data_o.sample_rate_out));
        if (out_data_o.data_length_out !== want.data_length_out)
          note_mismatch("data_length_out", flat_t'(want.data_length_out),
                        flat_t'(out_data_o.data_length_out));
        if (out_data_o.last_in_run !== want.last_in_run)
          note_mismatch("last_in_run", flat_t'(want.last_in_run),
                        flat_t'(out_data_o.last_in_run));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    in_t         stim;
    out_t        want;
    int          total;
    int          body;
    int          at;
    int          pick;
    int          roll;
    logic [15:0] chans;
    logic [15:0] depth;
    logic [31:0] dlen;
    clear_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      stim.in_byte     = DirectedRows[i].by;
      stim.end_of_file = DirectedRows[i].eof;
      feed_byte(stim, !DirectedRows[i].typed);
      if (DirectedRows[i].typed && DirectedRows[i].has_status) begin
        want             = '0;
        want.item_kind   = KindStatus;
        want.status_code = DirectedRows[i].code;
        want.last_in_run = 1'b1;
        pending_results.push_back(want);
      end
    end

    while (bytes_sent < NumItems) begin
      file_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 90) begin
        chans = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 2)) : 16'($urandom);
        if ($urandom_range(99) < 80) depth = $urandom_range(1) ? 16'd16 : 16'd8;
        else depth = 16'($urandom);
        roll = $urandom_range(99);
        if (roll < 15) dlen = '0;
        else if (roll < 90) dlen = $urandom_range(1, 40);
        else dlen = $urandom;
        push_le(TagRiff, 4);
        push_le($urandom, 4);
        push_le(TagWave, 4);
        push_le(TagFmt, 4);
        push_le(FmtChunkLen, 4);
        push_le(32'(AudioPcm), 2);
        push_le(32'(chans), 2);
        push_le($urandom, 4);
        push_le($urandom, 4);
        push_le($urandom, 2);
        push_le(32'(depth), 2);
        push_le(TagData, 4);
        push_le(dlen, 4);
        body = (dlen > 48) ? $urandom_range(0, 48) : int'(dlen);
        if (pick >= 75) begin
          at = $urandom_range(43);
          file_bytes[at] = file_bytes[at] ^ 8'($urandom_range(1, 255));
        end
        roll = $urandom_range(99);
        if (roll < 70) total = 44 + body;
        else if (roll < 85) total = $urandom_range(1, 44 + body);
        else total = 44 + body + $urandom_range(1, 6);
      end else begin
        total = $urandom_range(1, 30);
      end
      while (file_bytes.size() > total) void'(file_bytes.pop_back());
      while (file_bytes.size() < total) file_bytes.push_back(8'($urandom));
      for (int i = 0; i < total; i++) begin
        stim.in_byte     = file_bytes[i];
        stim.end_of_file = (i == total - 1);
        feed_byte(stim, 1'b1);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
